FILE: hw/rtl/ism_pkg.sv
// Shared constants, codes and types of the integer stack machine executor.
package ism_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int DATA_W          = 32;
    localparam int MODE_W          = 4;
    localparam int SLOT_W          = 8;
    localparam int STATUS_W        = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH      = 4'd0,
        MODE_PUSH_SLOT = 4'd1,
        MODE_ADD       = 4'd2,
        MODE_SUB       = 4'd3,
        MODE_MUL       = 4'd4,
        MODE_DIV       = 4'd5,
        MODE_LESS      = 4'd6,
        MODE_GREATER   = 4'd7,
        MODE_EQUAL     = 4'd8,
        MODE_END       = 4'd9
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FETCH,
        S_DIVIDE,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

endpackage

FILE: hw/rtl/ism_ifs.sv
// Valid/ready channel interfaces for instructions and results.
interface ism_in_if;
    logic                                 valid;
    logic                                 ready;
    logic        [ism_pkg::MODE_W-1:0]    mode;
    logic signed [ism_pkg::DATA_W-1:0]    immediate;
    logic        [ism_pkg::SLOT_W-1:0]    slot;

    modport source (output valid, mode, immediate, slot, input ready);
    modport sink   (input valid, mode, immediate, slot, output ready);
endinterface

interface ism_out_if #(
    parameter int STACK_DEPTH = ism_pkg::STACK_DEPTH_DEF
);
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

    logic                                 valid;
    logic                                 ready;
    logic signed [ism_pkg::DATA_W-1:0]    value;
    logic                                 cond_flag;
    logic                                 done_res;
    logic        [ism_pkg::STATUS_W-1:0]  status;
    logic        [DEPTH_W-1:0]            depth;

    modport source (output valid, value, cond_flag, done_res, status, depth, input ready);
    modport sink   (input valid, value, cond_flag, done_res, status, depth, output ready);
endinterface

FILE: hw/rtl/ism_stack_mem.sv
// Stack memory with one write port and one registered read port.
module ism_stack_mem #(
    parameter int STACK_DEPTH = ism_pkg::STACK_DEPTH_DEF,
    parameter int AW          = $clog2(ism_pkg::STACK_DEPTH_DEF)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [ism_pkg::DATA_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [ism_pkg::DATA_W-1:0] rdata
);
    import ism_pkg::*;

    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/ism_alu.sv
// Shared arithmetic and compare unit with a registered result.
module ism_alu (
    input  logic                       clk,
    input  logic                       load,
    input  ism_pkg::mode_t             op,
    input  logic [ism_pkg::DATA_W-1:0] lhs,
    input  logic [ism_pkg::DATA_W-1:0] rhs,
    output logic [ism_pkg::DATA_W-1:0] result,
    output logic                       flag
);
    import ism_pkg::*;

    logic [DATA_W-1:0]   result_reg;
    logic [DATA_W-1:0]   result_next;
    logic                flag_reg;
    logic                flag_next;
    logic [DATA_W-1:0]   product;

    assign product = lhs * rhs;

    always_comb
    begin
        result_next = lhs;
        flag_next   = 1'b0;
        case (op)
            MODE_ADD:     result_next = lhs + rhs;
            MODE_SUB:     result_next = lhs - rhs;
            MODE_MUL:     result_next = product;
            MODE_LESS:    flag_next   = $signed(lhs) < $signed(rhs);
            MODE_GREATER: flag_next   = $signed(rhs) < $signed(lhs);
            MODE_EQUAL:   flag_next   = (lhs == rhs);
            default:      result_next = lhs;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
            flag_reg   <= flag_next;
        end
    end

    assign result = result_reg;
    assign flag   = flag_reg;

endmodule

FILE: hw/rtl/ism_div.sv
// Bit-serial signed divider that truncates toward zero.
module ism_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ism_pkg::div_req_t          req,
    output logic                       busy,
    output logic [ism_pkg::DATA_W-1:0] quotient
);
    import ism_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic              busy_reg;
    logic              busy_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] den_reg;
    logic              neg_reg;
    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] a_mag;
    logic [DATA_W-1:0] b_mag;

    assign a_mag     = req.dividend[DATA_W-1] ? (DATA_W'(0) - req.dividend) : req.dividend;
    assign b_mag     = req.divisor[DATA_W-1] ? (DATA_W'(0) - req.divisor) : req.divisor;
    assign rem_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign diff      = rem_shift - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= a_mag;
            den_reg <= b_mag;
            neg_reg <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= diff[DATA_W] ? rem_shift[DATA_W-1:0] : diff[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], ~diff[DATA_W]};
        end
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

FILE: hw/rtl/integer_stack_machine_executor.sv
// Integer stack machine executor: runs one instruction at a time against a stack memory
// with one write port and one registered read port. An item is taken only in the idle
// state. A push, an unused mode code or any rejected instruction goes from check
// straight to commit; push slot, end, add, sub, mul, divide and the compares pass a
// fetch state for the memory read of the lower operand, of the copied slot or, for end,
// of the bottom entry; divide then waits in a divide state while the divider resolves
// one quotient bit per cycle. A finished result waits in an output register while the
// next item is taken, and that item's commit stalls until the previous result is accepted.
module integer_stack_machine_executor #(
    parameter int STACK_DEPTH = ism_pkg::STACK_DEPTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    ism_in_if.sink   in_ch,
    ism_out_if.source out_ch
);
    import ism_pkg::*;

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int CW   = (SP_W > SLOT_W) ? SP_W : SLOT_W;

    state_t            state_reg;
    state_t            state_next;
    logic [MODE_W-1:0] mode_reg;
    logic [DATA_W-1:0] imm_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SP_W-1:0]   sp_reg;
    logic [SP_W-1:0]   sp_next;
    logic [DATA_W-1:0] tos_reg;
    logic [DATA_W-1:0] tos_next;
    logic              flag_reg;
    logic              flag_next;
    status_t           status_reg;
    status_t           check_status;

    logic              out_valid_reg;
    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic              cond_reg;
    logic              done_reg;
    status_t           ostatus_reg;
    logic [SP_W-1:0]   depth_reg;

    logic              in_ready;
    logic              mem_re;
    logic              alu_load;
    logic              commit_fire;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;
    logic [DATA_W-1:0] alu_result;
    logic              alu_flag;
    logic              div_busy;
    logic [DATA_W-1:0] div_q;
    div_req_t          div_req;
    logic [SP_W-1:0]   sp_less2;
    logic              cmd_ok;

    assign sp_less2 = sp_reg - SP_W'(2);
    assign cmd_ok   = (status_reg == ST_OK);

    ism_stack_mem #(
        .STACK_DEPTH (STACK_DEPTH),
        .AW          (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ism_alu u_alu (
        .clk    (clk),
        .load   (alu_load),
        .op     (mode_t'(mode_reg)),
        .lhs    (mem_rdata),
        .rhs    (tos_reg),
        .result (alu_result),
        .flag   (alu_flag)
    );

    ism_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // Error check of the latched instruction against the current stack.
    always_comb
    begin
        check_status = ST_OK;
        unique case (mode_reg) inside
            MODE_PUSH:
            begin
                if (sp_reg == SP_W'(STACK_DEPTH))
                begin
                    check_status = ST_OVER;
                end
            end
            MODE_PUSH_SLOT:
            begin
                if (CW'(slot_reg) >= CW'(sp_reg))
                begin
                    check_status = ST_UNDER;
                end
                else if (sp_reg == SP_W'(STACK_DEPTH))
                begin
                    check_status = ST_OVER;
                end
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_LESS, MODE_GREATER, MODE_EQUAL:
            begin
                if (sp_reg < SP_W'(2))
                begin
                    check_status = ST_UNDER;
                end
                else if ((mode_reg == MODE_DIV) && (tos_reg == '0))
                begin
                    check_status = ST_DIVZ;
                end
            end
            MODE_END:
            begin
                if (sp_reg == '0)
                begin
                    check_status = ST_UNDER;
                end
            end
            default: check_status = ST_OK;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if ((check_status == ST_OK) &&
                    ((mode_reg == MODE_PUSH_SLOT) || (mode_reg == MODE_END) ||
                     ((mode_reg >= MODE_ADD) && (mode_reg <= MODE_EQUAL))))
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_FETCH:
            begin
                state_next = (mode_reg == MODE_DIV) ? S_DIVIDE : S_COMMIT;
            end
            S_DIVIDE:
            begin
                if (!div_busy)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready         = 1'b0;
        mem_re           = 1'b0;
        alu_load         = 1'b0;
        commit_fire      = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = mem_rdata;
        div_req.divisor  = tos_reg;
        unique case (state_reg)
            S_IDLE:   in_ready = 1'b1;
            S_CHECK:  mem_re = 1'b1;
            S_FETCH:
            begin
                alu_load      = 1'b1;
                div_req.start = (mode_reg == MODE_DIV);
            end
            S_DIVIDE: in_ready = 1'b0;
            S_COMMIT: commit_fire = !out_valid_reg || out_ch.ready;
            default:  in_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        if (mode_reg == MODE_PUSH_SLOT)
        begin
            mem_raddr = CW'(slot_reg) < CW'(STACK_DEPTH) ? AW'(slot_reg) : '0;
        end
        else if (mode_reg == MODE_END)
        begin
            mem_raddr = '0;
        end
        else
        begin
            mem_raddr = sp_less2[AW-1:0];
        end
    end

    // Stack update and result of the instruction at commit.
    always_comb
    begin
        mem_we     = 1'b0;
        mem_waddr  = sp_reg[AW-1:0];
        mem_wdata  = imm_reg;
        sp_next    = sp_reg;
        tos_next   = tos_reg;
        flag_next  = flag_reg;
        unique case (mode_reg) inside
            MODE_PUSH, MODE_PUSH_SLOT:
            begin
                mem_wdata = (mode_reg == MODE_PUSH) ? imm_reg : mem_rdata;
                if (cmd_ok)
                begin
                    mem_we   = commit_fire;
                    sp_next  = sp_reg + SP_W'(1);
                    tos_next = mem_wdata;
                end
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV:
            begin
                mem_waddr = sp_less2[AW-1:0];
                mem_wdata = (mode_reg == MODE_DIV) ? div_q : alu_result;
                if (cmd_ok)
                begin
                    mem_we   = commit_fire;
                    sp_next  = sp_reg - SP_W'(1);
                    tos_next = mem_wdata;
                end
            end
            MODE_LESS, MODE_GREATER, MODE_EQUAL:
            begin
                if (cmd_ok)
                begin
                    flag_next = alu_flag;
                end
            end
            MODE_END: sp_next = '0;
            default:  sp_next = sp_reg;
        endcase
        if (mode_reg == MODE_END)
        begin
            value_next = cmd_ok ? mem_rdata : '0;
        end
        else
        begin
            value_next = (sp_next == '0) ? '0 : tos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit_fire)
            begin
                sp_reg        <= sp_next;
                flag_reg      <= flag_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_ch.valid)
        begin
            mode_reg <= in_ch.mode;
            imm_reg  <= in_ch.immediate;
            slot_reg <= in_ch.slot;
        end
        if (state_reg == S_CHECK)
        begin
            status_reg <= check_status;
        end
        if (commit_fire)
        begin
            tos_reg     <= tos_next;
            value_reg   <= value_next;
            cond_reg    <= flag_next;
            done_reg    <= (mode_reg == MODE_END);
            ostatus_reg <= status_reg;
            depth_reg   <= sp_next;
        end
    end

    assign in_ch.ready      = in_ready;
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.value     = value_reg;
    assign out_ch.cond_flag = cond_reg;
    assign out_ch.done_res  = done_reg;
    assign out_ch.status    = ostatus_reg;
    assign out_ch.depth     = depth_reg;

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("Stack pointer is beyond the stack depth.");

    a_err_keeps_sp: assert property (@(posedge clk) disable iff (!rst_n)
        (commit_fire && (status_reg != ST_OK) && (mode_reg != MODE_END)) |=> $stable(sp_reg))
        else $error("A rejected instruction changed the stack pointer.");

    a_div_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == S_DIVIDE))
        else $error("Divider is busy outside the divide state.");

    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_COMMIT))
        else $error("A result appeared without a commit.");

endmodule

FILE: verif/integer_stack_machine_executor_tb.sv
// Self-checking testbench for the integer stack machine executor.
`timescale 1ns / 100ps

module integer_stack_machine_executor_tb;
    import ism_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 5;
    localparam int STACK_DEPTH  = STACK_DEPTH_DEF;
    localparam int DEPTH_W      = $clog2(STACK_DEPTH + 1);
    localparam int RANDOM_ITEMS = 1350;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PLAN_COPY    = 0;
    localparam int LIVE_COPY    = 1;

    localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] MINUS_1 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] immediate;
        logic [SLOT_W-1:0] slot;
    } instr_t;

    typedef struct packed {
        logic [DATA_W-1:0]   value;
        logic                cond_flag;
        logic                done_res;
        logic [STATUS_W-1:0] status;
        logic [DEPTH_W-1:0]  depth;
    } result_t;

    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   in_valid  = 1'b0;
    instr_t in_item   = '0;
    logic   out_ready = 1'b0;

    ism_in_if instr_ch ();
    ism_out_if #(.STACK_DEPTH(STACK_DEPTH)) result_ch ();

    assign instr_ch.valid     = in_valid;
    assign instr_ch.mode      = in_item.mode;
    assign instr_ch.immediate = in_item.immediate;
    assign instr_ch.slot      = in_item.slot;
    assign result_ch.ready    = out_ready;

    integer_stack_machine_executor #(.STACK_DEPTH(STACK_DEPTH)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (instr_ch),
        .out_ch (result_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Two copies of the machine state: one tracks the stream while it is built,
    // the other follows the items as the block accepts them.
    logic [DATA_W-1:0]  stack_mem [2][STACK_DEPTH];
    logic [DEPTH_W-1:0] stack_ptr [2] = '{'0, '0};
    logic               cmp_flag  [2] = '{1'b0, 1'b0};

    instr_t  pending_instrs[$];
    result_t expected_results[$];
    int      accepted_cnt = 0;
    int      item_total   = 0;
    int      phase_len    = 0;
    int      err_cnt      = 0;
    int      cycle_cnt    = 0;
    int      run_phase;
    int      send_gap_pct;
    int      recv_gap_pct;

    assign run_phase    = (accepted_cnt < phase_len) ? 0 : (accepted_cnt < 2 * phase_len) ? 1 : 2;
    assign send_gap_pct = (run_phase == 0) ? 11 : (run_phase == 1) ? 53 : 0;
    assign recv_gap_pct = (run_phase == 0) ? 53 : (run_phase == 1) ? 11 : 0;

    function automatic result_t execute_instr(input int c, input instr_t ins);
        result_t            r;
        logic [DEPTH_W-1:0] sp;
        logic [DATA_W-1:0]  lhs;
        logic [DATA_W-1:0]  rhs;
        logic [DATA_W-1:0]  mag_l;
        logic [DATA_W-1:0]  mag_r;
        logic [DATA_W-1:0]  quot;
        logic               ended;
        r      = '0;
        ended  = 1'b0;
        sp     = stack_ptr[c];
        r.status = ST_OK;
        case (ins.mode)
            MODE_PUSH:
                if (sp >= STACK_DEPTH)
                    r.status = ST_OVER;
                else
                begin
                    stack_mem[c][sp] = ins.immediate;
                    sp = sp + 1'b1;
                end
            MODE_PUSH_SLOT:
                if (DEPTH_W'(ins.slot) >= sp)
                    r.status = ST_UNDER;
                else if (sp >= STACK_DEPTH)
                    r.status = ST_OVER;
                else
                begin
                    stack_mem[c][sp] = stack_mem[c][ins.slot];
                    sp = sp + 1'b1;
                end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_LESS, MODE_GREATER, MODE_EQUAL:
                if (sp < 2)
                    r.status = ST_UNDER;
                else
                begin
                    lhs = stack_mem[c][sp - 2];
                    rhs = stack_mem[c][sp - 1];
                    case (ins.mode)
                        MODE_ADD:
                        begin
                            stack_mem[c][sp - 2] = lhs + rhs;
                            sp = sp - 1'b1;
                        end
                        MODE_SUB:
                        begin
                            stack_mem[c][sp - 2] = lhs - rhs;
                            sp = sp - 1'b1;
                        end
                        MODE_MUL:
                        begin
                            stack_mem[c][sp - 2] = lhs * rhs;
                            sp = sp - 1'b1;
                        end
                        MODE_DIV:
                            if (rhs == '0)
                                r.status = ST_DIVZ;
                            else
                            begin
                                // Divide magnitudes and restore the sign, so that the most
                                // negative value over minus one wraps back to itself.
                                mag_l = lhs[DATA_W-1] ? -lhs : lhs;
                                mag_r = rhs[DATA_W-1] ? -rhs : rhs;
                                quot  = mag_l / mag_r;
                                stack_mem[c][sp - 2] = (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? -quot : quot;
                                sp = sp - 1'b1;
                            end
                        MODE_LESS:    cmp_flag[c] = $signed(lhs) < $signed(rhs);
                        MODE_GREATER: cmp_flag[c] = $signed(lhs) > $signed(rhs);
                        default:      cmp_flag[c] = (lhs == rhs);
                    endcase
                end
            MODE_END:
            begin
                ended      = 1'b1;
                r.done_res = 1'b1;
                if (sp == 0)
                begin
                    r.status = ST_UNDER;
                    r.value  = '0;
                end
                else
                    r.value = stack_mem[c][0];
                sp = '0;
            end
            default:
            begin
            end
        endcase
        stack_ptr[c] = sp;
        if (!ended)
            r.value = (sp == 0) ? '0 : stack_mem[c][sp - 1];
        r.cond_flag = cmp_flag[c];
        r.depth     = sp;
        return r;
    endfunction

    task automatic queue_instr(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] imm,
                               input logic [SLOT_W-1:0] slot);
        instr_t ins;
        ins.mode      = mode;
        ins.immediate = imm;
        ins.slot      = slot;
        pending_instrs.push_back(ins);
        void'(execute_instr(PLAN_COPY, ins));
    endtask

    function automatic logic [DATA_W-1:0] rand_operand();
        case ($urandom_range(9))
            0, 1, 2, 3: return DATA_W'($urandom_range(40)) - 32'd20;
            4:          return INT_MIN;
            5:          return INT_MAX;
            6:          return MINUS_1;
            7:          return '0;
            default:    return $urandom();
        endcase
    endfunction

    // Empties and fills the stack, pushes when full, compares, multiplies, copies, ends.
    task automatic fill_stack_to_overflow();
        queue_instr(MODE_END, rand_operand(), 8'($urandom_range(255)));
        while (stack_ptr[PLAN_COPY] < STACK_DEPTH)
        begin
            if (stack_ptr[PLAN_COPY] != 0 && $urandom_range(3) == 0)
                queue_instr(MODE_PUSH_SLOT, $urandom(),
                            8'($urandom_range(int'(stack_ptr[PLAN_COPY]) - 1)));
            else
                queue_instr(MODE_PUSH, rand_operand(), 8'($urandom_range(255)));
        end
        queue_instr(MODE_PUSH, rand_operand(), 8'($urandom_range(255)));
        queue_instr(MODE_PUSH_SLOT, $urandom(), 8'($urandom_range(255)));
        queue_instr(MODE_GREATER, $urandom(), 8'($urandom_range(255)));
        queue_instr(MODE_MUL, $urandom(), 8'($urandom_range(255)));
        queue_instr(MODE_PUSH_SLOT, $urandom(), 8'(STACK_DEPTH - 2));
        queue_instr(MODE_END, $urandom(), 8'($urandom_range(255)));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && instr_ch.ready)
            begin
                expected_results.push_back(execute_instr(LIVE_COPY, in_item));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!in_valid || instr_ch.ready)
            begin
                if (pending_instrs.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    in_item  <= pending_instrs.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off at the start of the last
    // phase while the sender keeps offering items.
    int  hold_left = 0;
    logic hold_used = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (!hold_used && phase_len != 0 && accepted_cnt >= 2 * phase_len)
        begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && result_ch.valid && out_ready)
        begin
            got.value     = result_ch.value;
            got.cond_flag = result_ch.cond_flag;
            got.done_res  = result_ch.done_res;
            got.status    = result_ch.status;
            got.depth     = result_ch.depth;
            if (expected_results.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected result: expected none, actual value=%0d flag=%b done=%b status=%0d depth=%0d",
                         $time, $signed(got.value), got.cond_flag, got.done_res,
                         got.status, got.depth);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    err_cnt++;
                    $display("%0t: result mismatch: expected value=%0d flag=%b done=%b status=%0d depth=%0d",
                             $time, $signed(want.value), want.cond_flag, want.done_res,
                             want.status, want.depth);
                    $display("%0t:                  actual   value=%0d flag=%b done=%b status=%0d depth=%0d",
                             $time, $signed(got.value), got.cond_flag, got.done_res,
                             got.status, got.depth);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("integer_stack_machine_executor_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        int roll;
        int steps;
        int depth_now;
        int directed_cnt;
        logic fill_a;
        logic fill_b;
        fill_a = 1'b0;
        fill_b = 1'b0;

        // Errors on an empty stack, then the extremes, every operation and the
        // division corner cases.
        queue_instr(MODE_ADD, '0, '0);
        queue_instr(MODE_END, '0, '0);
        queue_instr(MODE_PUSH_SLOT, '0, '0);
        queue_instr(MODE_PUSH, INT_MAX, '0);
        queue_instr(MODE_PUSH, INT_MIN, '0);
        queue_instr(MODE_LESS, '0, '0);
        queue_instr(MODE_GREATER, '0, '0);
        queue_instr(MODE_EQUAL, '0, '0);
        queue_instr(MODE_PUSH_SLOT, '0, 8'd0);
        queue_instr(MODE_PUSH_SLOT, '0, 8'hFF);
        queue_instr(MODE_ADD, '0, '0);
        queue_instr(MODE_PUSH, '0, '0);
        queue_instr(MODE_DIV, '0, '0);
        queue_instr(MODE_ADD, '0, '0);
        queue_instr(MODE_MUL, '0, '0);
        queue_instr(MODE_PUSH, INT_MIN, '0);
        queue_instr(MODE_PUSH, MINUS_1, '0);
        queue_instr(MODE_DIV, '0, '0);
        queue_instr(MODE_SUB, '0, '0);
        queue_instr(MODE_PUSH, -32'sd7, '0);
        queue_instr(MODE_PUSH, 32'd2, '0);
        queue_instr(MODE_DIV, '0, '0);
        queue_instr(4'hF, MINUS_1, 8'hFF);
        queue_instr(MODE_END + 4'd1, '0, '0);
        queue_instr(MODE_END, '0, '0);
        directed_cnt = pending_instrs.size();

        while (pending_instrs.size() < directed_cnt + RANDOM_ITEMS)
        begin
            if (!fill_a && pending_instrs.size() >= 300)
            begin
                fill_a = 1'b1;
                fill_stack_to_overflow();
            end
            else if (!fill_b && pending_instrs.size() >= 1000)
            begin
                fill_b = 1'b1;
                fill_stack_to_overflow();
            end
            roll = $urandom_range(99);
            if (roll < 10)
                queue_instr(4'($urandom_range(15)), $urandom(), 8'($urandom_range(255)));
            else
            begin
                repeat ($urandom_range(4, 1))
                    queue_instr(MODE_PUSH, rand_operand(), 8'($urandom_range(255)));
                steps = $urandom_range(10, 2);
                repeat (steps)
                begin
                    depth_now = int'(stack_ptr[PLAN_COPY]);
                    roll = $urandom_range(9);
                    if (roll < 2 || depth_now < 2)
                        queue_instr(MODE_PUSH, rand_operand(), 8'($urandom_range(255)));
                    else if (roll < 3)
                    begin
                        if ($urandom_range(9) == 0)
                            queue_instr(MODE_PUSH_SLOT, $urandom(), 8'($urandom_range(255)));
                        else
                            queue_instr(MODE_PUSH_SLOT, $urandom(),
                                        8'($urandom_range(depth_now - 1)));
                    end
                    else
                        queue_instr(4'(MODE_ADD + $urandom_range(6)), $urandom(),
                                    8'($urandom_range(255)));
                end
                if ($urandom_range(3) != 0)
                    queue_instr(MODE_END, $urandom(), 8'($urandom_range(255)));
            end
        end
        item_total = pending_instrs.size();
        phase_len  = item_total / 3;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_cnt < item_total || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0)
            $display("integer_stack_machine_executor_tb: done, clean");
        else
            $display("integer_stack_machine_executor_tb: done, errors");
        $finish;
    end

endmodule
